### sv/lkc_pkg.sv
// lkc_pkg: shared types for the lru key cache
// item and result records used by the stages and the table
// no dependencies
package lkc_pkg;

    // function codes of an input item
    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_FLUSH  = 1'b1;

    // field widths of the result record
    localparam int SLOT_W = 4;
    localparam int OCC_W  = 5;
    localparam int KEY_W  = 32;

    // one input item
    typedef struct packed {
        logic             func;
        logic [KEY_W-1:0] user_id;
        logic [KEY_W-1:0] group_id;
    } lkc_item_t;

    // one result item
    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              evicted;
        logic [KEY_W-1:0]  evicted_user;
        logic [KEY_W-1:0]  evicted_group;
        logic [OCC_W-1:0]  occupancy;
    } lkc_result_t;

endpackage

### sv/lkc_if.sv
// lkc_req_if and lkc_rsp_if: valid/ready channels of the lru key cache
// carry the item and result fields; depend on nothing else
interface lkc_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [31:0] user_id;
    logic [31:0] group_id;

    modport source (output valid, output func, output user_id, output group_id, input ready);
    modport sink   (input valid, input func, input user_id, input group_id, output ready);
endinterface

interface lkc_rsp_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [3:0]  slot;
    logic        evicted;
    logic [31:0] evicted_user;
    logic [31:0] evicted_group;
    logic [4:0]  occupancy;

    modport source (output valid, output hit, output slot, output evicted,
                    output evicted_user, output evicted_group, output occupancy,
                    input ready);
    modport sink   (input valid, input hit, input slot, input evicted,
                    input evicted_user, input evicted_group, input occupancy,
                    output ready);
endinterface

### sv/lkc_in_stage.sv
// lkc_in_stage: input register of the lru key cache
// depends on lkc_pkg and lkc_req_if
module lkc_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    lkc_req_if.sink           req,
    input  logic              take,
    output logic              s1_valid,
    output lkc_pkg::lkc_item_t s1_item
);
    import lkc_pkg::*;

    logic      valid_reg;
    lkc_item_t item_reg;

    // stage can load when empty or when its item moves on
    assign req.ready = !valid_reg || take;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            valid_reg <= req.valid;
        end
    end

    // item payload
    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            item_reg <= '{func: req.func, user_id: req.user_id, group_id: req.group_id};
        end
    end

    assign s1_valid = valid_reg;
    assign s1_item  = item_reg;

endmodule

### sv/lkc_table.sv
// lkc_table: key store, valid bits, ages and count with the lookup and lru update
// depends on lkc_pkg
module lkc_table #(
    parameter int CAPACITY = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  lkc_pkg::lkc_item_t  item,
    output lkc_pkg::lkc_result_t result
);
    import lkc_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [IW-1:0] AGE_MAX = IW'(CAPACITY - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(CAPACITY);

    logic [KEY_W-1:0] user_reg  [CAPACITY];
    logic [KEY_W-1:0] group_reg [CAPACITY];
    logic [CAPACITY-1:0] valid_reg, valid_next;
    logic [IW-1:0]    age_reg  [CAPACITY];
    logic [IW-1:0]    age_next [CAPACITY];
    logic [CW-1:0]    count_reg, count_next;

    logic          found, full;
    logic [IW-1:0] hit_idx, free_idx, old_idx, tgt_idx, hit_age;

    // parallel key compare and priority picks, lowest index wins
    always_comb
    begin
        found    = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        old_idx  = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && user_reg[i] == item.user_id && group_reg[i] == item.group_id)
            begin
                found   = 1'b1;
                hit_idx = IW'(i);
            end
            if (!valid_reg[i])
            begin
                free_idx = IW'(i);
            end
            if (valid_reg[i] && age_reg[i] == AGE_MAX)
            begin
                old_idx = IW'(i);
            end
        end
    end

    assign full    = (count_reg >= CNT_FULL);
    assign tgt_idx = full ? old_idx : free_idx;
    assign hit_age = age_reg[hit_idx];

    // next state of valid bits, ages and count
    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        for (int i = 0; i < CAPACITY; i++)
        begin
            age_next[i] = age_reg[i];
        end
        if (item.func == FUNC_FLUSH)
        begin
            valid_next = '0;
            count_next = '0;
            for (int i = 0; i < CAPACITY; i++)
            begin
                age_next[i] = '0;
            end
        end
        else if (found)
        begin
            // entries younger than the hit one move back by one
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (valid_reg[i] && age_reg[i] < hit_age)
                begin
                    age_next[i] = age_reg[i] + 1'b1;
                end
            end
            age_next[hit_idx] = '0;
        end
        else
        begin
            // insert as most recent, every other valid entry ages
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (IW'(i) != tgt_idx && valid_reg[i] && age_reg[i] < AGE_MAX)
                begin
                    age_next[i] = age_reg[i] + 1'b1;
                end
            end
            age_next[tgt_idx]   = '0;
            valid_next[tgt_idx] = 1'b1;
            if (!full)
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    // result of the current item
    always_comb
    begin
        result = '0;
        if (item.func != FUNC_FLUSH)
        begin
            result.hit  = found;
            result.slot = SLOT_W'(found ? hit_idx : tgt_idx);
            if (!found && full)
            begin
                result.evicted       = 1'b1;
                result.evicted_user  = user_reg[old_idx];
                result.evicted_group = group_reg[old_idx];
            end
        end
        result.occupancy = OCC_W'(count_next);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < CAPACITY; i++)
            begin
                age_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            for (int i = 0; i < CAPACITY; i++)
            begin
                age_reg[i] <= age_next[i];
            end
        end
    end

    // key store, written on a miss
    always_ff @(posedge clk)
    begin
        if (fire && item.func != FUNC_FLUSH && !found)
        begin
            user_reg[tgt_idx]  <= item.user_id;
            group_reg[tgt_idx] <= item.group_id;
        end
    end

endmodule

### sv/lkc_out_stage.sv
// lkc_out_stage: result register of the lru key cache
// depends on lkc_pkg and lkc_rsp_if
module lkc_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  lkc_pkg::lkc_result_t result,
    output logic                 advance,
    lkc_rsp_if.source            rsp
);
    import lkc_pkg::*;

    logic        valid_reg;
    lkc_result_t data_reg;

    // register is free when empty or its item is taken this cycle
    assign advance = !valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && load)
        begin
            data_reg <= result;
        end
    end

    assign rsp.valid         = valid_reg;
    assign rsp.hit           = data_reg.hit;
    assign rsp.slot          = data_reg.slot;
    assign rsp.evicted       = data_reg.evicted;
    assign rsp.evicted_user  = data_reg.evicted_user;
    assign rsp.evicted_group = data_reg.evicted_group;
    assign rsp.occupancy     = data_reg.occupancy;

endmodule

### sv/lru_key_cache_core.sv
// lru_key_cache_core: top level of the fully associative lru key cache
// depends on lkc_pkg, lkc_if, lkc_in_stage, lkc_table, lkc_out_stage
//
// usage
//   req channel: one item per handshake, func 0 looks up or inserts the key
//   (user_id, group_id), func 1 flushes every entry
//   rsp channel: exactly one result item per request item, in order
//   path: an item is registered in the input register, then in the result register
//   throughput: one item per cycle while rsp.ready is high; the key compare
//   against all CAPACITY entries and the age update are combinational between
//   the input register and the result register
//   reset: every entry invalid, all ages and the count zero; no clearing
//   pass, req.ready is high as soon as reset is released
//   stall: a result held by a low rsp.ready stays stable; the input register
//   keeps one more item, then req.ready drops until the result is taken
//   if CAPACITY is above 16, slot carries the low bits only; occupancy does so above 31
module lru_key_cache_core #(
    parameter int CAPACITY = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    lkc_req_if.sink    req,
    lkc_rsp_if.source  rsp
);
    import lkc_pkg::*;

    logic        s1_valid;
    lkc_item_t   s1_item;
    logic        advance;
    logic        fire;
    lkc_result_t result;

    // item in the input register moves to the result register
    assign fire = s1_valid && advance;

    lkc_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .take     (advance),
        .s1_valid (s1_valid),
        .s1_item  (s1_item)
    );

    lkc_table #(
        .CAPACITY (CAPACITY)
    ) u_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (s1_item),
        .result (result)
    );

    lkc_out_stage u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (s1_valid),
        .result  (result),
        .advance (advance),
        .rsp     (rsp)
    );

endmodule

### sv/lkc_checker.sv
// lkc_checker: port level assertions for the lru key cache, bound to the top
// depends on lru_key_cache_core
module lkc_checker #(
    parameter int CAPACITY = 16
) (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        hit,
    input logic [3:0]  slot,
    input logic        evicted,
    input logic [31:0] evicted_user,
    input logic [31:0] evicted_group,
    input logic [4:0]  occupancy
);

    // a stalled result stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(hit) && $stable(slot) && $stable(evicted)
            && $stable(evicted_user) && $stable(evicted_group) && $stable(occupancy))
        else $error("result changed while stalled");

    // a hit never replaces an entry
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && hit |-> !evicted)
        else $error("hit reported an eviction");

    // evicted key fields are zero unless an entry was replaced
    a_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !evicted |-> evicted_user == 32'd0 && evicted_group == 32'd0)
        else $error("evicted key without eviction");

    // eviction only happens with the cache full
    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && evicted |-> occupancy == 5'(CAPACITY))
        else $error("eviction with free room");

endmodule

bind lru_key_cache_core lkc_checker #(
    .CAPACITY (CAPACITY)
) u_lkc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .hit           (rsp.hit),
    .slot          (rsp.slot),
    .evicted       (rsp.evicted),
    .evicted_user  (rsp.evicted_user),
    .evicted_group (rsp.evicted_group),
    .occupancy     (rsp.occupancy)
);

### bench/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for lru_key_cache_core, a 16-entry lru key cache
// keeps its own copy of the cache contents and checks every result item in order
// depends on lkc_pkg, lkc_if and the core rtl
module tb_top;
    import lkc_pkg::*;

    localparam int CAPACITY    = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int POOL_MAX    = 32;

    logic clk = 1'b0;
    logic rst_n;

    lkc_req_if req_ch ();
    lkc_rsp_if rsp_ch ();

    lru_key_cache_core #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // shadow copy of the cache
    logic [31:0] shadow_user [CAPACITY];
    logic [31:0] shadow_group [CAPACITY];
    logic        shadow_valid [CAPACITY];
    int          shadow_age [CAPACITY];
    int          shadow_count;

    lkc_result_t cache_answers [$];

    int mismatch_count = 0;
    int cycle_count = 0;
    int rsp_stall_left = 0;
    bit req_idle;
    bit rsp_idle;

    // keys reused by the random tests so that hits and evictions happen
    logic [31:0] key_user [POOL_MAX];
    logic [31:0] key_group [POOL_MAX];

    // apply one item to the shadow cache and return the result it must give
    function automatic lkc_result_t lru_access(logic f, logic [31:0] u, logic [31:0] g);
        lkc_result_t r;
        int found;
        int victim;
        int oldest;
        int hit_age;
        r = '0;
        found = -1;
        victim = -1;
        oldest = 0;
        if (f == FUNC_FLUSH)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                shadow_valid[i] = 1'b0;
                shadow_age[i] = 0;
            end
            shadow_count = 0;
            return r;
        end
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (found < 0 && shadow_valid[i] && shadow_user[i] == u && shadow_group[i] == g)
                found = i;
        end
        // hit: younger entries age by one, hit entry becomes most recent
        if (found >= 0)
        begin
            hit_age = shadow_age[found];
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (shadow_valid[i] && shadow_age[i] < hit_age)
                    shadow_age[i]++;
            end
            shadow_age[found] = 0;
            r.hit = 1'b1;
            r.slot = found[SLOT_W-1:0];
            r.occupancy = shadow_count[OCC_W-1:0];
            return r;
        end
        // miss when full: replace the oldest valid entry
        if (shadow_count >= CAPACITY)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (shadow_valid[i] && (victim < 0 || shadow_age[i] > oldest))
                begin
                    victim = i;
                    oldest = shadow_age[i];
                end
            end
            if (victim < 0)
                victim = 0;
            r.evicted = 1'b1;
            r.evicted_user = shadow_user[victim];
            r.evicted_group = shadow_group[victim];
        end
        // miss with room: lowest free entry
        else
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (victim < 0 && !shadow_valid[i])
                    victim = i;
            end
            if (victim < 0)
                victim = 0;
            shadow_count++;
        end
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (i != victim && shadow_valid[i] && shadow_age[i] < CAPACITY - 1)
                shadow_age[i]++;
        end
        shadow_valid[victim] = 1'b1;
        shadow_user[victim] = u;
        shadow_group[victim] = g;
        shadow_age[victim] = 0;
        r.slot = victim[SLOT_W-1:0];
        r.occupancy = shadow_count[OCC_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    // compare one accepted result item with the oldest expectation
    task automatic check_answer();
        lkc_result_t want;
        if (cache_answers.size() == 0)
        begin
            report_mismatch("result item with no lookup pending");
            return;
        end
        want = cache_answers[0];
        cache_answers.delete(0);
        compare_field("hit", 32'(rsp_ch.hit), 32'(want.hit));
        compare_field("slot", 32'(rsp_ch.slot), 32'(want.slot));
        compare_field("evicted", 32'(rsp_ch.evicted), 32'(want.evicted));
        compare_field("evicted_user", rsp_ch.evicted_user, want.evicted_user);
        compare_field("evicted_group", rsp_ch.evicted_group, want.evicted_group);
        compare_field("occupancy", 32'(rsp_ch.occupancy), 32'(want.occupancy));
    endtask

    // result side: take an item, then, when rsp_idle is set, hold ready low for a random stall
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_stall_left = 0;
            rsp_ch.ready <= 1'b0;
        end
        else if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            check_answer();
            rsp_stall_left = rsp_idle ? $urandom_range(0, 10) : 0;
            if (rsp_stall_left > 0)
                rsp_ch.ready <= 1'b0;
        end
        else if (rsp_ch.ready !== 1'b1)
        begin
            if (rsp_stall_left > 0)
                rsp_stall_left--;
            if (rsp_stall_left == 0)
                rsp_ch.ready <= 1'b1;
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // send one item; valid stays high when the next item follows without a gap
    task automatic issue_item(input logic f, input logic [31:0] u, input logic [31:0] g);
        int gap;
        gap = req_idle ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.func     <= f;
        req_ch.user_id  <= u;
        req_ch.group_id <= g;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        cache_answers.push_back(lru_access(f, u, g));
    endtask

    task automatic pick_idling();
        req_idle = ($urandom_range(0, 3) != 0);
        rsp_idle = ($urandom_range(0, 3) != 0);
    endtask

    // fill the key pool; some neighbors share a user id and differ in group
    task automatic build_key_pool(input int n);
        for (int i = 0; i < n; i++)
        begin
            key_user[i] = (i % 3 == 2) ? key_user[i-1] : $urandom;
            key_group[i] = (i % 5 == 4) ? key_group[i-1] : $urandom;
        end
    endtask

    task automatic issue_pool_key(input int n);
        int idx;
        idx = $urandom_range(0, n - 1);
        issue_item(FUNC_LOOKUP, key_user[idx], key_group[idx]);
    endtask

    // extremes, fill, eviction order, hit reordering and flush
    task automatic test_directed();
        req_idle = 1'b0;
        rsp_idle = 1'b0;
        issue_item(FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        issue_item(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue_item(FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        issue_item(FUNC_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
        issue_item(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
        for (int i = 0; i < CAPACITY - 4; i++)
            issue_item(FUNC_LOOKUP, 32'h1000 + i, 32'h2000 + i);
        // full now: each miss replaces the oldest entry
        issue_item(FUNC_LOOKUP, 32'hAAAA_5555, 32'h5555_AAAA);
        issue_item(FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        issue_item(FUNC_LOOKUP, 32'h5555_AAAA, 32'hAAAA_5555);
        issue_item(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // flush full cache, flush empty cache, then refill from slot 0
        issue_item(FUNC_FLUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue_item(FUNC_FLUSH, 32'h0000_0000, 32'h0000_0000);
        issue_item(FUNC_LOOKUP, 32'h0000_0001, 32'h0000_0002);
    endtask

    // working set smaller than the cache: mostly hits
    task automatic test_hot_set();
        build_key_pool(12);
        for (int i = 0; i < 600; i++)
        begin
            if (i % 100 == 0)
                pick_idling();
            if ($urandom_range(0, 199) == 0)
                issue_item(FUNC_FLUSH, $urandom, $urandom);
            else
                issue_pool_key(12);
        end
    endtask

    // working set larger than the cache, skewed toward a hot part
    task automatic test_thrash();
        build_key_pool(24);
        for (int i = 0; i < 600; i++)
        begin
            if (i % 100 == 0)
                pick_idling();
            if ($urandom_range(0, 299) == 0)
                issue_item(FUNC_FLUSH, $urandom, $urandom);
            else if ($urandom_range(0, 9) < 7)
                issue_pool_key(14);
            else
                issue_pool_key(24);
        end
    endtask

    // fresh random keys with some reuse and frequent flushes
    task automatic test_random_keys();
        int idx;
        logic [31:0] u;
        logic [31:0] g;
        build_key_pool(POOL_MAX);
        for (int i = 0; i < 500; i++)
        begin
            if (i % 100 == 0)
                pick_idling();
            if ($urandom_range(0, 39) == 0)
                issue_item(FUNC_FLUSH, $urandom, $urandom);
            else if ($urandom_range(0, 3) == 0)
                issue_pool_key(POOL_MAX);
            else
            begin
                u = $urandom;
                g = $urandom;
                idx = $urandom_range(0, POOL_MAX - 1);
                key_user[idx] = u;
                key_group[idx] = g;
                issue_item(FUNC_LOOKUP, u, g);
            end
        end
    endtask

    // drain the pending results and give the verdict
    task automatic finish_run();
        req_ch.valid <= 1'b0;
        while (cache_answers.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.func = FUNC_LOOKUP;
        req_ch.user_id = '0;
        req_ch.group_id = '0;
        req_idle = 1'b0;
        rsp_idle = 1'b0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            shadow_user[i] = '0;
            shadow_group[i] = '0;
            shadow_valid[i] = 1'b0;
            shadow_age[i] = 0;
        end
        shadow_count = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_hot_set();
        test_thrash();
        test_random_keys();
        finish_run();
    end

endmodule
